FILE: rtl/ppu_pkg.sv
// Package for the packed pattern unpacker: parse phase type, byte codes and
// the small decode functions. No dependencies.
`default_nettype none

package ppu_pkg;

    // Parse phase of the byte stream.
    typedef enum logic [2:0] {
        PH_CHAN,   // expect a channel byte or an end-of-row zero
        PH_MASK,   // expect a new field mask byte
        PH_REUSE,  // stored mask is arriving from memory with this byte
        PH_NOTE,
        PH_INS,
        PH_VOL,
        PH_FXT,
        PH_FXP
    } phase_t;

    localparam logic [7:0] ROW_MAX         = 8'd255;
    localparam logic [7:0] NEW_MASK_FLAG   = 8'h80;
    localparam logic [7:0] NOTE_EMPTY_CODE = 8'd255;
    localparam logic [7:0] NOTE_OFF_CODE   = 8'd254;
    localparam logic [6:0] NOTE_KEY_OFF    = 7'h61;
    localparam logic [7:0] NOTE_OFFSET     = 8'd11;
    localparam logic [7:0] NOTE_MAX        = 8'd96;
    localparam logic [7:0] VOL_MAX         = 8'h40;
    localparam logic [7:0] VOL_BIAS        = 8'h10;

    // First selected field at or after field k; PH_CHAN when none remains.
    function automatic phase_t phase_from(input logic [3:0] m, input logic [1:0] k);
        phase_t ph;
        priority if (m[0] && k == 2'd0) begin
            ph = PH_NOTE;
        end else if (m[1] && k <= 2'd1) begin
            ph = PH_INS;
        end else if (m[2] && k <= 2'd2) begin
            ph = PH_VOL;
        end else if (m[3]) begin
            ph = PH_FXT;
        end else begin
            ph = PH_CHAN;
        end
        return ph;
    endfunction

    // Raw note byte to 0 empty, 1..96 note, 97 key off.
    function automatic logic [6:0] convert_note(input logic [7:0] b);
        logic [7:0] n;
        n = b - NOTE_OFFSET;
        priority if (b == NOTE_EMPTY_CODE) begin
            return 7'd0;
        end else if (b == NOTE_OFF_CODE) begin
            return NOTE_KEY_OFF;
        end else if (n > NOTE_MAX) begin
            return 7'd0;
        end else begin
            return n[6:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/packed_pattern_unpacker.sv
// Packed pattern unpacker: decodes a packed tracker pattern byte stream
// into channel events. Depends on ppu_pkg.
//
// Usage: bytes of one packed pattern enter on the s_ channel, one word per
// byte, with s_tuser high on the first byte of a pattern (clears the row
// counter, all channel masks and the parse state before that byte is used).
// Each completed channel event leaves on the m_ channel as one 56-bit word.
// Throughput is one byte per cycle. An event appears on m_tvalid the cycle
// after its last byte is taken. The per-channel field masks live in a
// 64-entry memory with a registered read; a mask read for a channel byte is
// consumed together with the following byte, so no cycle is lost. Valid
// bits beside the memory make reset and pattern start clear all masks at
// once; no clearing pass is needed. Synchronous reset (aresetn low) clears
// the parse state and drops any event waiting on the output. The output is
// a single register: while it holds an event and m_tready is low, s_tready
// is low; when m_tready is high a new byte is taken in the same cycle the
// waiting event is delivered.
`default_nettype none

module packed_pattern_unpacker #(
    parameter int CHANNEL_COUNT = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: [7:0] data_byte
    input  wire  [7:0]  s_tdata,
    // s_tuser: [0] pattern_start
    input  wire  [0:0]  s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // m_tdata: [7:0] row_index, [13:8] channel_index, [14] note_valid,
    // [21:15] note_value, [22] instrument_valid, [30:23] instrument_value,
    // [31] volume_valid, [38:32] volume_value, [39] effect_valid,
    // [47:40] effect_type, [55:48] effect_param
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready
);

    localparam int ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // Mask memory, its valid bits and the registered read port.
    logic [3:0]               mask_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] mask_vld_reg, mask_vld_next;
    logic [3:0]               rd_data_reg;
    logic                     rd_vld_reg;

    // Parse state.
    ppu_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      row_reg, row_next;
    logic [5:0]      chan_reg, chan_next;
    logic [3:0]      mask_reg, mask_next;
    logic [6:0]      note_reg, note_next;
    logic [7:0]      ins_reg, ins_next;
    logic            vol_ok_reg, vol_ok_next;
    logic [6:0]      vol_reg, vol_next;
    logic [7:0]      fxt_reg, fxt_next;

    // Output register.
    logic        out_vld_reg, out_vld_next;
    logic [55:0] out_data_reg, out_data_next;

    logic            accept;
    logic            pstart;
    logic [7:0]      b;
    ppu_pkg::phase_t cur_phase, eff_phase;
    logic [7:0]      cur_row;
    logic [3:0]      eff_mask;
    logic [5:0]      b_chan;
    logic            b_in_range, chan_in_range;
    logic [ADDR_W-1:0] b_addr, chan_addr;
    logic            wr_en, rd_en, emit;
    logic [7:0]      vol_sum;

    assign s_tready = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pstart   = s_tuser[0];
    assign b        = s_tdata;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Channel selected by a channel byte, and memory addressing.
    assign b_chan        = 6'(b - 8'd1);
    assign b_in_range    = {1'b0, b_chan} < 7'(CHANNEL_COUNT);
    assign chan_in_range = {1'b0, chan_reg} < 7'(CHANNEL_COUNT);
    assign b_addr        = ADDR_W'(b_chan);
    assign chan_addr     = ADDR_W'(chan_reg);
    assign vol_sum       = b + ppu_pkg::VOL_BIAS;

    // Effective state for this byte: pattern start clears first, and a
    // reused mask arriving from memory starts the event right here.
    always_comb begin
        cur_phase = pstart ? ppu_pkg::PH_CHAN : phase_reg;
        cur_row   = pstart ? 8'd0 : row_reg;
        if (cur_phase == ppu_pkg::PH_REUSE) begin
            eff_mask  = rd_vld_reg ? rd_data_reg : 4'd0;
            eff_phase = ppu_pkg::phase_from(eff_mask, 2'd0);
        end else begin
            eff_mask  = mask_reg;
            eff_phase = cur_phase;
        end
    end

    // Next parse phase.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (eff_phase)
                ppu_pkg::PH_CHAN: begin
                    if (b == 8'd0) begin
                        phase_next = ppu_pkg::PH_CHAN;
                    end else if ((b & ppu_pkg::NEW_MASK_FLAG) != 8'd0) begin
                        phase_next = ppu_pkg::PH_MASK;
                    end else begin
                        phase_next = ppu_pkg::PH_REUSE;
                    end
                end
                ppu_pkg::PH_MASK:  phase_next = ppu_pkg::phase_from(b[3:0], 2'd0);
                ppu_pkg::PH_NOTE:  phase_next = ppu_pkg::phase_from(eff_mask, 2'd1);
                ppu_pkg::PH_INS:   phase_next = ppu_pkg::phase_from(eff_mask, 2'd2);
                ppu_pkg::PH_VOL:   phase_next = ppu_pkg::phase_from(eff_mask, 2'd3);
                ppu_pkg::PH_FXT:   phase_next = ppu_pkg::PH_FXP;
                ppu_pkg::PH_FXP:   phase_next = ppu_pkg::PH_CHAN;
                ppu_pkg::PH_REUSE: phase_next = ppu_pkg::PH_CHAN;
                default:           phase_next = ppu_pkg::PH_CHAN;
            endcase
        end
    end

    // Datapath, memory controls and event emission.
    always_comb begin
        row_next      = row_reg;
        chan_next     = chan_reg;
        mask_next     = mask_reg;
        note_next     = note_reg;
        ins_next      = ins_reg;
        vol_ok_next   = vol_ok_reg;
        vol_next      = vol_reg;
        fxt_next      = fxt_reg;
        mask_vld_next = mask_vld_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        emit          = 1'b0;
        if (accept) begin
            row_next  = cur_row;
            mask_next = eff_mask;
            if (pstart) begin
                mask_vld_next = '0;
            end
            unique case (eff_phase)
                ppu_pkg::PH_CHAN: begin
                    if (b == 8'd0) begin
                        if (cur_row != ppu_pkg::ROW_MAX) begin
                            row_next = cur_row + 8'd1;
                        end
                    end else begin
                        chan_next = b_chan;
                        rd_en     = 1'b1;
                    end
                end
                ppu_pkg::PH_MASK: begin
                    mask_next = b[3:0];
                    if (chan_in_range) begin
                        wr_en                    = 1'b1;
                        mask_vld_next[chan_addr] = 1'b1;
                    end
                end
                ppu_pkg::PH_NOTE: begin
                    note_next = ppu_pkg::convert_note(b);
                    emit      = ppu_pkg::phase_from(eff_mask, 2'd1) == ppu_pkg::PH_CHAN;
                end
                ppu_pkg::PH_INS: begin
                    ins_next = b;
                    emit     = ppu_pkg::phase_from(eff_mask, 2'd2) == ppu_pkg::PH_CHAN;
                end
                ppu_pkg::PH_VOL: begin
                    vol_ok_next = b <= ppu_pkg::VOL_MAX;
                    vol_next    = (b <= ppu_pkg::VOL_MAX) ? vol_sum[6:0] : 7'd0;
                    emit        = ppu_pkg::phase_from(eff_mask, 2'd3) == ppu_pkg::PH_CHAN;
                end
                ppu_pkg::PH_FXT: begin
                    fxt_next = b;
                end
                ppu_pkg::PH_FXP: begin
                    emit = 1'b1;
                end
                ppu_pkg::PH_REUSE: begin
                    emit = 1'b0;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Output register: load a new event, or drop the delivered one.
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (accept && emit) begin
            out_vld_next = 1'b1;
            out_data_next = {
                mask_next[3] ? b : 8'd0,
                mask_next[3] ? fxt_next : 8'd0,
                mask_next[3],
                (mask_next[2] && vol_ok_next) ? vol_next : 7'd0,
                mask_next[2] && vol_ok_next,
                mask_next[1] ? ins_next : 8'd0,
                mask_next[1],
                mask_next[0] ? note_next : 7'd0,
                mask_next[0],
                chan_reg,
                row_next
            };
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    // Mask memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mask_mem[chan_addr] <= b[3:0];
        end
        if (rd_en) begin
            rd_data_reg <= mask_mem[b_addr];
            rd_vld_reg  <= b_in_range && !pstart && mask_vld_reg[b_addr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ppu_pkg::PH_CHAN;
            row_reg      <= 8'd0;
            chan_reg     <= 6'd0;
            mask_reg     <= 4'd0;
            mask_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            row_reg      <= row_next;
            chan_reg     <= chan_next;
            mask_reg     <= mask_next;
            mask_vld_reg <= mask_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        note_reg     <= note_next;
        ins_reg      <= ins_next;
        vol_ok_reg   <= vol_ok_next;
        vol_reg      <= vol_next;
        fxt_reg      <= fxt_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: bench/packed_pattern_unpacker_tb.sv
// Self-checking bench for packed_pattern_unpacker: drives packed pattern bytes,
// predicts the decoded channel events and checks every output word.
// Depends on ppu_pkg and the packed_pattern_unpacker RTL.
`timescale 1ns / 100ps

module packed_pattern_unpacker_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 50;

    // One decoded event, laid out exactly as m_tdata (lowest field last).
    typedef struct packed {
        logic [7:0] effect_param;
        logic [7:0] effect_type;
        logic       effect_valid;
        logic [6:0] volume_value;
        logic       volume_valid;
        logic [7:0] instrument_value;
        logic       instrument_valid;
        logic [6:0] note_value;
        logic       note_valid;
        logic [5:0] channel_index;
        logic [7:0] row_index;
    } event_t;

    // Fields gathered while an event is being parsed.
    typedef struct {
        logic [3:0] mask;
        logic [6:0] note;
        logic [7:0] ins;
        logic       vol_ok;
        logic [6:0] vol;
        logic [7:0] fxt;
        logic [7:0] fxp;
    } partial_event_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    // Decoder state as the bench expects it.
    logic [3:0]       chan_mask [64];
    logic [7:0]       row_cnt;
    logic [5:0]       cur_chan;
    ppu_pkg::phase_t  dec_phase;
    partial_event_t   pend;

    event_t expected_events [$];
    int     mismatch_count = 0;
    int     sent_items     = 0;
    int     cycle_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_idle_pct  = 0;
    int     hold_cycles    = 0;

    packed_pattern_unpacker #(
        .CHANNEL_COUNT(64)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // Compare each delivered word with the oldest expected event.
    always @(posedge aclk) begin : result_check
        event_t got;
        event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_events.size() == 0) begin
                report_mismatch("word with no event expected", m_tdata, 0);
            end else begin
                want = expected_events.pop_front();
                if (got.row_index != want.row_index)
                    report_mismatch("row_index", got.row_index, want.row_index);
                if (got.channel_index != want.channel_index)
                    report_mismatch("channel_index", got.channel_index, want.channel_index);
                if (got.note_valid != want.note_valid)
                    report_mismatch("note_valid", got.note_valid, want.note_valid);
                if (got.note_value != want.note_value)
                    report_mismatch("note_value", got.note_value, want.note_value);
                if (got.instrument_valid != want.instrument_valid)
                    report_mismatch("instrument_valid", got.instrument_valid,
                                    want.instrument_valid);
                if (got.instrument_value != want.instrument_value)
                    report_mismatch("instrument_value", got.instrument_value,
                                    want.instrument_value);
                if (got.volume_valid != want.volume_valid)
                    report_mismatch("volume_valid", got.volume_valid, want.volume_valid);
                if (got.volume_value != want.volume_value)
                    report_mismatch("volume_value", got.volume_value, want.volume_value);
                if (got.effect_valid != want.effect_valid)
                    report_mismatch("effect_valid", got.effect_valid, want.effect_valid);
                if (got.effect_type != want.effect_type)
                    report_mismatch("effect_type", got.effect_type, want.effect_type);
                if (got.effect_param != want.effect_param)
                    report_mismatch("effect_param", got.effect_param, want.effect_param);
            end
        end
    end

    // Reset and pattern start both clear the whole decode state.
    function automatic void clear_decoder_state();
        foreach (chan_mask[i]) chan_mask[i] = 4'd0;
        row_cnt   = 8'd0;
        cur_chan  = 6'd0;
        dec_phase = ppu_pkg::PH_CHAN;
        pend      = '{default: '0};
    endfunction

    // Phase of the first field selected by the mask at or after field k.
    function automatic ppu_pkg::phase_t first_field_at(input logic [3:0] m, input int k);
        for (int i = k; i < 4; i++) begin
            if (m[i]) begin
                case (i)
                    0: return ppu_pkg::PH_NOTE;
                    1: return ppu_pkg::PH_INS;
                    2: return ppu_pkg::PH_VOL;
                    default: return ppu_pkg::PH_FXT;
                endcase
            end
        end
        return ppu_pkg::PH_CHAN;
    endfunction

    // Raw note byte to 0 empty, 1..96 note, 97 key off.
    function automatic logic [6:0] note_code(input logic [7:0] b);
        logic [7:0] shifted;
        shifted = b - ppu_pkg::NOTE_OFFSET;
        if (b == ppu_pkg::NOTE_EMPTY_CODE) return 7'd0;
        if (b == ppu_pkg::NOTE_OFF_CODE) return ppu_pkg::NOTE_KEY_OFF;
        if (shifted > ppu_pkg::NOTE_MAX) return 7'd0;
        return shifted[6:0];
    endfunction

    function automatic void open_event(input logic [3:0] m);
        pend      = '{default: '0};
        pend.mask = m;
        dec_phase = first_field_at(m, 0);
    endfunction

    // Advance the expected decode state by one accepted byte.
    function automatic void decode_byte(input logic [7:0] b, input logic start);
        logic   done;
        event_t ev;
        done = 1'b0;
        if (start)
            clear_decoder_state();
        case (dec_phase)
            ppu_pkg::PH_CHAN: begin
                if (b == 8'd0) begin
                    if (row_cnt != ppu_pkg::ROW_MAX) row_cnt++;
                end else begin
                    cur_chan = b[5:0] - 6'd1;
                    if ((b & ppu_pkg::NEW_MASK_FLAG) != 8'd0) dec_phase = ppu_pkg::PH_MASK;
                    else open_event(chan_mask[cur_chan]);
                end
            end
            ppu_pkg::PH_MASK: begin
                chan_mask[cur_chan] = b[3:0];
                open_event(b[3:0]);
            end
            ppu_pkg::PH_NOTE: begin
                pend.note = note_code(b);
                dec_phase = first_field_at(pend.mask, 1);
                done      = (dec_phase == ppu_pkg::PH_CHAN);
            end
            ppu_pkg::PH_INS: begin
                pend.ins  = b;
                dec_phase = first_field_at(pend.mask, 2);
                done      = (dec_phase == ppu_pkg::PH_CHAN);
            end
            ppu_pkg::PH_VOL: begin
                pend.vol_ok = (b <= ppu_pkg::VOL_MAX);
                pend.vol    = pend.vol_ok ? 7'(b + ppu_pkg::VOL_BIAS) : 7'd0;
                dec_phase   = first_field_at(pend.mask, 3);
                done        = (dec_phase == ppu_pkg::PH_CHAN);
            end
            ppu_pkg::PH_FXT: begin
                pend.fxt  = b;
                dec_phase = ppu_pkg::PH_FXP;
            end
            ppu_pkg::PH_FXP: begin
                pend.fxp  = b;
                dec_phase = ppu_pkg::PH_CHAN;
                done      = 1'b1;
            end
            default: dec_phase = ppu_pkg::PH_CHAN;
        endcase
        if (done) begin
            ev.row_index        = row_cnt;
            ev.channel_index    = cur_chan;
            ev.note_valid       = pend.mask[0];
            ev.note_value       = pend.mask[0] ? pend.note : 7'd0;
            ev.instrument_valid = pend.mask[1];
            ev.instrument_value = pend.mask[1] ? pend.ins : 8'd0;
            ev.volume_valid     = pend.mask[2] && pend.vol_ok;
            ev.volume_value     = ev.volume_valid ? pend.vol : 7'd0;
            ev.effect_valid     = pend.mask[3];
            ev.effect_type      = pend.mask[3] ? pend.fxt : 8'd0;
            ev.effect_param     = pend.mask[3] ? pend.fxp : 8'd0;
            expected_events.push_back(ev);
        end
    endfunction

    // Offer one byte, with random idle cycles first, and wait for its handshake.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, start);
        sent_items++;
    endtask

    // Stop offering and wait until every expected event has been delivered.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Field byte for the current parse phase, biased toward the edge values.
    function automatic logic [7:0] pick_field_byte(input ppu_pkg::phase_t ph);
        case (ph)
            ppu_pkg::PH_NOTE: begin
                case ($urandom_range(3))
                    0: return $urandom_range(1) ? ppu_pkg::NOTE_EMPTY_CODE
                                                : ppu_pkg::NOTE_OFF_CODE;
                    1: return 8'($urandom_range(11, 107));
                    default: return 8'($urandom);
                endcase
            end
            ppu_pkg::PH_VOL: begin
                case ($urandom_range(3))
                    0: return $urandom_range(1) ? ppu_pkg::VOL_MAX
                                                : ppu_pkg::VOL_MAX + 8'd1;
                    1: return 8'($urandom_range(0, 64));
                    default: return 8'($urandom);
                endcase
            end
            default: return ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom);
        endcase
    endfunction

    // One random stream element: mostly complete channel entries, some row
    // ends, some noise, and now and then a pattern start cutting an entry.
    task automatic send_random_entry();
        int         pick;
        int         ch;
        int         wrap;
        logic [7:0] chb;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_byte(8'd0, $urandom_range(49) == 0);
        end else if (pick < 17) begin
            send_byte(8'($urandom), $urandom_range(24) == 0);
        end else begin
            // A few channels get most traffic so stored masks are reused.
            do begin
                ch   = $urandom_range(1) ? $urandom_range(3) : $urandom_range(63);
                wrap = $urandom_range(3);
                chb  = 8'(ch + 1 + 64 * wrap);
            end while (chb == 8'd0);
            send_byte(chb, $urandom_range(49) == 0);
            while (dec_phase != ppu_pkg::PH_CHAN) begin
                if ($urandom_range(99) == 0) send_byte(8'($urandom), 1'b1);
                else send_byte(pick_field_byte(dec_phase), 1'b0);
            end
        end
    endtask

    // Field extremes, new and reused masks, empty masks and row ends.
    task automatic test_directed_fields();
        send_idle_pct = 10;
        recv_idle_pct = 51;
        // Channel 0, all fields: empty note, zero instrument and effect type, volume 64.
        send_byte(8'h81, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Channel 63, mask with upper bits set, key off.
        send_byte(8'hC0, 1'b0);
        send_byte(8'hF1, 1'b0);
        send_byte(ppu_pkg::NOTE_OFF_CODE, 1'b0);
        // Channel 63 again with its stored mask, highest note.
        send_byte(8'h40, 1'b0);
        send_byte(8'h6B, 1'b0);
        send_byte(8'h00, 1'b0);
        // Volume above 64 is dropped.
        send_byte(8'h82, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(ppu_pkg::VOL_MAX + 8'd1, 1'b0);
        // An empty mask, stored and then reused, gives no event.
        send_byte(8'h83, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        // Reused full mask: a note that wraps below zero, volume zero.
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_for_drain();
    endtask

    // The row counter must stop at its maximum.
    task automatic test_row_saturation();
        send_byte(8'h00, 1'b1);
        repeat (259) send_byte(8'h00, 1'b0);
        send_byte(8'h86, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h30, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = sent_items + items;
        while (sent_items < stop_at) send_random_entry();
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        repeat (40) send_random_entry();
        wait_for_drain();
    endtask

    // The sender stops mid-run until all events are out, then resumes.
    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (25) send_random_entry();
        wait_for_drain();
        repeat (25) send_random_entry();
        wait_for_drain();
    endtask

    initial begin
        clear_decoder_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_fields();
        test_row_saturation();
        test_random_traffic(190, 10, 51);
        test_random_traffic(190, 51, 10);
        test_random_traffic(190, 0, 0);
        test_output_stall();
        test_sender_pause();

        // Allow any late or stray word to show up before the verdict.
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ppu_pkg.sv
rtl/packed_pattern_unpacker.sv
bench/packed_pattern_unpacker_tb.sv
